### hdl/pcb_pkg.sv
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared types and codes of the pixel color blender: beat structs, stage
// structs, configuration layout and operand select codes.
// ----------------------------------------------------------------------------
package pcb_pkg;

	// Channel vector: [3] red, [2] green, [1] blue, [0] alpha.
	typedef logic [3:0][7:0] rgba_t;

	// Input beat.
	typedef struct packed {
		logic [7:0] comb_red;
		logic [7:0] comb_green;
		logic [7:0] comb_blue;
		logic [7:0] comb_alpha;
		logic [7:0] fb_red;
		logic [7:0] fb_green;
		logic [7:0] fb_blue;
		logic [7:0] fb_alpha;
		logic [7:0] shade_alpha;
		logic [7:0] coverage;
		logic       cycle_sel;
	} pix_in_t;

	// Result beat.
	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} pix_out_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [15:0] blender_mux;
		logic [31:0] fog_color;
		logic [31:0] blend_color;
		logic        force_blend;
	} cfg_t;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_BLENDER_MUX = 2'd0;
	localparam logic [1:0] REG_FOG_COLOR   = 2'd1;
	localparam logic [1:0] REG_BLEND_COLOR = 2'd2;
	localparam logic [1:0] REG_FORCE_BLEND = 2'd3;

	// P and M color source codes.
	localparam logic [1:0] COL_COMB  = 2'd0;
	localparam logic [1:0] COL_FB    = 2'd1;
	localparam logic [1:0] COL_BLEND = 2'd2;
	localparam logic [1:0] COL_FOG   = 2'd3;

	// A weight source codes.
	localparam logic [1:0] WA_COMB  = 2'd0;
	localparam logic [1:0] WA_FOG   = 2'd1;
	localparam logic [1:0] WA_SHADE = 2'd2;
	localparam logic [1:0] WA_ZERO  = 2'd3;

	// B weight source codes.
	localparam logic [1:0] WB_INV_A = 2'd0;
	localparam logic [1:0] WB_CVG   = 2'd1;
	localparam logic [1:0] WB_FULL  = 2'd2;
	localparam logic [1:0] WB_ZERO  = 2'd3;

	// Fixed-point constants.
	localparam int          WGT_SHIFT = 5;
	localparam int          ALPHA_SHIFT = 3;
	localparam logic [4:0]  WGT_MAX = 5'h1F;
	localparam logic [7:0]  CH_MAX = 8'd255;

	// Stage 1: operands chosen.
	typedef struct packed {
		logic       valid;
		logic       pass;
		rgba_t      p;
		rgba_t      m;
		logic [4:0] a;
		logic [7:0] b;
	} stage1_t;

	// Stage 2: products formed.
	typedef struct packed {
		logic             valid;
		logic             pass;
		rgba_t            p;
		logic [3:0][12:0] pa;
		logic [3:0][15:0] mb;
	} stage2_t;

endpackage

### hdl/pcb_select.sv
// ----------------------------------------------------------------------------
// pcb_select
// First stage: decodes the mux codes of the chosen cycle and registers the
// P and M colors and the A and B weights.
// ----------------------------------------------------------------------------
module pcb_select
	import pcb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  pix_in_t pixel_in,
	input  cfg_t    cfg,
	output stage1_t stage1
);

	rgba_t      comb;
	rgba_t      fb;
	logic [1:0] code_p;
	logic [1:0] code_a;
	logic [1:0] code_m;
	logic [1:0] code_b;
	rgba_t      p_sel;
	rgba_t      m_sel;
	logic [4:0] a_sel;
	logic [7:0] b_sel;

	function automatic rgba_t pick_color(input logic [1:0] code, input rgba_t c,
		input rgba_t f, input logic [31:0] blend, input logic [31:0] fog);
		rgba_t r;
		case (code)
			COL_COMB:  r = c;
			COL_FB:    r = f;
			COL_BLEND: r = blend;
			COL_FOG:   r = fog;
			default:   r = fog;
		endcase
		return r;
	endfunction

	// Gather the two input colors in register layout.
	assign comb = {pixel_in.comb_red, pixel_in.comb_green, pixel_in.comb_blue,
		pixel_in.comb_alpha};
	assign fb = {pixel_in.fb_red, pixel_in.fb_green, pixel_in.fb_blue, pixel_in.fb_alpha};

	// The cycle select picks the upper or lower code of each pair.
	assign code_p = pixel_in.cycle_sel ? cfg.blender_mux[13:12] : cfg.blender_mux[15:14];
	assign code_a = pixel_in.cycle_sel ? cfg.blender_mux[9:8]   : cfg.blender_mux[11:10];
	assign code_m = pixel_in.cycle_sel ? cfg.blender_mux[5:4]   : cfg.blender_mux[7:6];
	assign code_b = pixel_in.cycle_sel ? cfg.blender_mux[1:0]   : cfg.blender_mux[3:2];

	assign p_sel = pick_color(code_p, comb, fb, cfg.blend_color, cfg.fog_color);
	assign m_sel = pick_color(code_m, comb, fb, cfg.blend_color, cfg.fog_color);

	// A weight: an alpha reduced to five bits, or zero.
	always_comb begin
		case (code_a)
			WA_COMB:  a_sel = pixel_in.comb_alpha[7:ALPHA_SHIFT];
			WA_FOG:   a_sel = cfg.fog_color[7:ALPHA_SHIFT];
			WA_SHADE: a_sel = pixel_in.shade_alpha[7:ALPHA_SHIFT];
			WA_ZERO:  a_sel = 5'd0;
			default:  a_sel = 5'd0;
		endcase
	end

	// B weight: inverse of A, the coverage, the maximum weight, or zero.
	always_comb begin
		case (code_b)
			WB_INV_A: b_sel = {3'd0, ~a_sel};
			WB_CVG:   b_sel = pixel_in.coverage;
			WB_FULL:  b_sel = {3'd0, WGT_MAX};
			WB_ZERO:  b_sel = 8'd0;
			default:  b_sel = 8'd0;
		endcase
	end

	// Stage register: valid bit and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage1 <= '0;
		end else begin
			stage1.valid <= load;
			stage1.pass  <= ~cfg.force_blend;
			stage1.p     <= p_sel;
			stage1.m     <= m_sel;
			stage1.a     <= a_sel;
			stage1.b     <= b_sel;
		end
	end

endmodule

### hdl/pcb_mult.sv
// ----------------------------------------------------------------------------
// pcb_mult
// Second stage: forms the P*A and M*B products of all four channels.
// ----------------------------------------------------------------------------
module pcb_mult
	import pcb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  stage1_t stage1,
	output stage2_t stage2
);

	logic [3:0][12:0] pa_prod;
	logic [3:0][15:0] mb_prod;

	// One small multiplier pair per channel.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pa_prod[i] = 13'(stage1.p[i]) * 13'(stage1.a);
			mb_prod[i] = 16'(stage1.m[i]) * 16'(stage1.b);
		end
	end

	// Stage register: valid bit and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage2 <= '0;
		end else begin
			stage2.valid <= stage1.valid;
			stage2.pass  <= stage1.pass;
			stage2.p     <= stage1.p;
			stage2.pa    <= pa_prod;
			stage2.mb    <= mb_prod;
		end
	end

endmodule

### hdl/pcb_sum.sv
// ----------------------------------------------------------------------------
// pcb_sum
// Third stage: adds the products, scales and saturates each channel (or passes
// the P color through), and holds the result beat with its strobe.
// ----------------------------------------------------------------------------
module pcb_sum
	import pcb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  stage2_t  stage2,
	output logic     done,
	output pix_out_t result
);

	logic [3:0][16:0] sum;
	rgba_t            blended;
	rgba_t            chan;

	// Sum, drop the fraction, clamp at full scale.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum[i] = 17'(stage2.pa[i]) + 17'(stage2.mb[i]);
			blended[i] = (|sum[i][16:13]) ? CH_MAX : sum[i][12:WGT_SHIFT];
		end
	end

	// With blending off the P color goes out untouched.
	assign chan = stage2.pass ? stage2.p : blended;

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= stage2.valid;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		result.out_red   <= chan[3];
		result.out_green <= chan[2];
		result.out_blue  <= chan[1];
		result.out_alpha <= chan[0];
	end

endmodule

### hdl/pixel_color_blender.sv
// ----------------------------------------------------------------------------
// pixel_color_blender
// Fixed-point alpha blender: one RGBA pixel per beat, three pipeline stages.
// ----------------------------------------------------------------------------
// Usage:
// An input beat is taken at a rising edge with start high and busy low.
// Busy stays low, so a new pixel can enter on every clock: the rate is one
// pixel per cycle, set by the three-stage pipeline (operand select, the
// per-channel multipliers, then add and saturate).
// The result beat appears on result with done high for exactly one cycle,
// after the stage 1, stage 2 and result registers; results leave in input order.
// The receiver cannot stall the block, and none is needed, since every
// stage advances on every clock.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data with no wait; they should change only while no pixel is in
// flight. Register 0 is the blender mux, 1 the fog color, 2 the blend
// color and 3 the force-blend bit.
// Reset clears all configuration registers and the stage valid bits, so
// pixels in flight are dropped and done stays low until new beats arrive.
// ----------------------------------------------------------------------------
module pixel_color_blender
	import pcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pix_in_t     pixel_in,
	output logic        done,
	output pix_out_t    result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic    accept;
	cfg_t    cfg_q;
	stage1_t stage1;
	stage2_t stage2;

	// The pipeline never holds off a beat.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLENDER_MUX: cfg_q.blender_mux <= cfg_data[15:0];
				REG_FOG_COLOR:   cfg_q.fog_color   <= cfg_data;
				REG_BLEND_COLOR: cfg_q.blend_color <= cfg_data;
				REG_FORCE_BLEND: cfg_q.force_blend <= cfg_data[0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	pcb_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.pixel_in (pixel_in),
		.cfg      (cfg_q),
		.stage1   (stage1)
	);

	pcb_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.stage1 (stage1),
		.stage2 (stage2)
	);

	pcb_sum u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.stage2 (stage2),
		.done   (done),
		.result (result)
	);

	// Every accepted beat yields its result after the stage 1, stage 2 and result registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("accepted beat produced no result");

	// No result appears without an accepted beat that produced it.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result without a matching input beat");

	// The first stage hands every valid beat on to the second.
	assert property (@(posedge clk) disable iff (!arst_n)
		stage1.valid |=> stage2.valid)
		else $error("beat lost between select and multiply");

	// With blending off, a valid pass-through beat leaves the red and alpha of its P color intact.
	assert property (@(posedge clk) disable iff (!arst_n)
		(stage2.valid && stage2.pass) |=>
			(result.out_red == $past(stage2.p[3]) &&
			result.out_alpha == $past(stage2.p[0])))
		else $error("pass-through pixel altered");

endmodule
